// ----- hdl/hrbe_pkg.sv -----
package hrbe_pkg;

	localparam int LEN_BITS = 32;
	localparam int KEY_LEN  = 14;
	localparam int POS_BITS = 4;
	localparam int QDEPTH   = 4;
	localparam int QAW      = $clog2(QDEPTH);

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [1:0] STATUS_DIGITS = 2'd3;

	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] low;
		logic [3:0] digit;
		logic       ws;
		logic       is_digit;
		logic       cr;
		logic       lf;
		logic       colon;
		logic       plus;
		logic       minus;
	} cls_t;

	typedef struct packed {
		logic       body_valid;
		logic [7:0] body_byte;
		logic       body_last;
		logic       parse_error;
	} res_t;

	function automatic logic [7:0] key_char(input logic [POS_BITS-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/hrbe_ifs.sv -----
interface hrbe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface hrbe_out_if;
	logic       valid;
	logic       ready;
	logic       body_valid;
	logic [7:0] body_byte;
	logic       body_last;
	logic       parse_error;

	modport source (output valid, output body_valid, output body_byte, output body_last,
		output parse_error, input ready);
	modport sink (input valid, input body_valid, input body_byte, input body_last,
		input parse_error, output ready);
endinterface

// ----- hdl/hrbe_front.sv -----
module hrbe_front (
	hrbe_in_if.sink       rx,
	input  logic          full,
	output logic          push,
	output hrbe_pkg::cls_t word
);

	logic [7:0] b;

	assign b       = rx.byte_in;
	assign rx.ready = !full;
	assign push    = rx.valid && !full;

	always_comb begin
		word.raw      = b;
		word.low      = (b >= hrbe_pkg::CH_UP_A && b <= hrbe_pkg::CH_UP_Z) ?
			b + hrbe_pkg::CASE_GAP : b;
		word.digit    = 4'(b - hrbe_pkg::CH_ZERO);
		word.ws       = (b >= hrbe_pkg::CH_TAB && b <= hrbe_pkg::CH_CR) ||
			b == hrbe_pkg::CH_SPACE;
		word.is_digit = b >= hrbe_pkg::CH_ZERO && b <= hrbe_pkg::CH_NINE;
		word.cr       = b == hrbe_pkg::CH_CR;
		word.lf       = b == hrbe_pkg::CH_LF;
		word.colon    = b == hrbe_pkg::CH_COLON;
		word.plus     = b == hrbe_pkg::CH_PLUS;
		word.minus    = b == hrbe_pkg::CH_MINUS;
	end

endmodule

// ----- hdl/hrbe_fifo.sv -----
module hrbe_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hrbe_pkg::cls_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           rvalid,
	output hrbe_pkg::cls_t rdata
);

	hrbe_pkg::cls_t                mem_q [hrbe_pkg::QDEPTH];
	logic [hrbe_pkg::QAW-1:0]      wptr_q;
	logic [hrbe_pkg::QAW-1:0]      rptr_q;
	logic [hrbe_pkg::QAW:0]        count_q;

	assign full   = count_q == (hrbe_pkg::QAW+1)'(hrbe_pkg::QDEPTH);
	assign rvalid = count_q != '0;
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/hrbe_back.sv -----
module hrbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           word_valid,
	input  hrbe_pkg::cls_t word,
	output logic           pop,
	hrbe_out_if.source     tx
);

	localparam int LB = hrbe_pkg::LEN_BITS;
	localparam int PB = hrbe_pkg::POS_BITS;

	typedef enum logic [3:0] {
		PH_WAIT_WS, PH_CODE, PH_TEXT, PH_HDR_BEGIN, PH_NAME,
		PH_SKIP, PH_VALUE, PH_BODY, PH_DONE, PH_ERROR
	} phase_t;

	phase_t         phase_q, phase_n;
	logic [1:0]     digits_q, digits_n;
	logic [PB-1:0]  pos_q, pos_n;
	logic           mis_q, mis_n;
	logic [LB-1:0]  acc_q, acc_n;
	logic           started_q, started_n;
	logic           neg_q, neg_n;
	logic           stop_q, stop_n;
	logic [LB-1:0]  remain_q, remain_n;
	hrbe_pkg::res_t res_q, res_n;
	logic           res_valid_q;

	logic           fresh;
	logic [LB-1:0]  acc_base;
	logic           st_base, neg_base, stop_base;
	logic [LB+3:0]  wide;
	logic [LB-1:0]  acc_dig;
	logic [LB-1:0]  vf_acc;
	logic           vf_st, vf_neg, vf_stop;
	logic [PB-1:0]  pos_base, nf_pos;
	logic           mis_base, nf_mis;
	logic           key_hit;

	assign pop = word_valid && (!res_valid_q || tx.ready);

	// value digit accumulate, saturating
	always_comb begin
		fresh     = phase_q == PH_SKIP;
		acc_base  = fresh ? '0 : acc_q;
		st_base   = fresh ? 1'b0 : started_q;
		neg_base  = fresh ? 1'b0 : neg_q;
		stop_base = fresh ? 1'b0 : stop_q;
		wide      = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
			{(LB)'(0), word.digit};
		acc_dig   = (|wide[LB+3:LB]) ? '1 : wide[LB-1:0];
		vf_acc    = acc_base;
		vf_st     = st_base;
		vf_neg    = neg_base;
		vf_stop   = stop_base;
		if (!stop_base) begin
			vf_st = 1'b1;
			if (!st_base && (word.plus || word.minus)) begin
				vf_neg = neg_base | word.minus;
			end else if (word.is_digit) begin
				vf_acc = acc_dig;
			end else begin
				vf_stop = 1'b1;
			end
		end
	end

	// header name compare
	always_comb begin
		pos_base = (phase_q == PH_HDR_BEGIN) ? '0 : pos_q;
		mis_base = (phase_q == PH_HDR_BEGIN) ? 1'b0 : mis_q;
		nf_pos   = pos_base;
		nf_mis   = mis_base;
		if (pos_base >= PB'(hrbe_pkg::KEY_LEN)) begin
			nf_mis = 1'b1;
		end else begin
			if (hrbe_pkg::key_char(pos_base) != word.low) begin
				nf_mis = 1'b1;
			end
			nf_pos = pos_base + 1'b1;
		end
		key_hit = !mis_q && pos_q == PB'(hrbe_pkg::KEY_LEN);
	end

	always_comb begin
		phase_n   = phase_q;
		digits_n  = digits_q;
		pos_n     = pos_q;
		mis_n     = mis_q;
		acc_n     = acc_q;
		started_n = started_q;
		neg_n     = neg_q;
		stop_n    = stop_q;
		remain_n  = remain_q;
		res_n     = '0;
		case (phase_q)
			PH_WAIT_WS: begin
				if (word.ws) begin
					digits_n = '0;
					phase_n  = PH_CODE;
				end
			end
			PH_CODE: begin
				if (digits_q != hrbe_pkg::STATUS_DIGITS) begin
					if (word.is_digit) begin
						digits_n = digits_q + 1'b1;
					end else begin
						phase_n = PH_ERROR;
					end
				end else begin
					phase_n = word.ws ? PH_TEXT : PH_ERROR;
				end
			end
			PH_TEXT: begin
				if (word.lf) begin
					phase_n = PH_HDR_BEGIN;
				end
			end
			PH_HDR_BEGIN, PH_NAME: begin
				if (phase_q == PH_HDR_BEGIN && word.cr) begin
					phase_n = PH_HDR_BEGIN;
				end else if (phase_q == PH_HDR_BEGIN && word.lf) begin
					phase_n = PH_BODY;
				end else if (word.colon) begin
					pos_n   = pos_base;
					mis_n   = mis_base;
					phase_n = PH_SKIP;
				end else begin
					pos_n   = nf_pos;
					mis_n   = nf_mis;
					phase_n = PH_NAME;
				end
			end
			PH_SKIP: begin
				if (!word.ws) begin
					acc_n     = vf_acc;
					started_n = vf_st;
					neg_n     = vf_neg;
					stop_n    = vf_stop;
					phase_n   = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (word.lf) begin
					if (key_hit) begin
						remain_n = neg_q ? '0 : acc_q;
					end
					phase_n = PH_HDR_BEGIN;
				end else begin
					acc_n     = vf_acc;
					started_n = vf_st;
					neg_n     = vf_neg;
					stop_n    = vf_stop;
				end
			end
			PH_BODY: begin
				res_n.body_valid = 1'b1;
				res_n.body_byte  = word.raw;
				if (remain_q <= LB'(1)) begin
					remain_n        = '0;
					res_n.body_last = 1'b1;
					phase_n         = PH_DONE;
				end else begin
					remain_n = remain_q - 1'b1;
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase
		res_n.parse_error = phase_n == PH_ERROR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_WS;
			digits_q    <= '0;
			pos_q       <= '0;
			mis_q       <= 1'b0;
			acc_q       <= '0;
			started_q   <= 1'b0;
			neg_q       <= 1'b0;
			stop_q      <= 1'b0;
			remain_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				digits_q    <= digits_n;
				pos_q       <= pos_n;
				mis_q       <= mis_n;
				acc_q       <= acc_n;
				started_q   <= started_n;
				neg_q       <= neg_n;
				stop_q      <= stop_n;
				remain_q    <= remain_n;
				res_valid_q <= 1'b1;
			end else if (tx.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	assign tx.valid       = res_valid_q;
	assign tx.body_valid  = res_q.body_valid;
	assign tx.body_byte   = res_q.body_byte;
	assign tx.body_last   = res_q.body_last;
	assign tx.parse_error = res_q.parse_error;

`ifndef NO_ASSERTIONS
	a_last_is_body: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.body_last |-> res_q.body_valid)
		else $error("last flag without body byte");
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("done phase left");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && phase_q == PH_BODY && remain_q > LB'(1) |=>
		remain_q == $past(remain_q) - LB'(1))
		else $error("body count not decremented");
`endif

endmodule

// ----- hdl/http_response_body_extractor.sv -----
// channel | dir | payload                                          | handshake
// rx      | in  | byte_in[7:0]                                     | valid/ready
// tx      | out | body_valid, body_byte[7:0], body_last, parse_error | valid/ready
//
// One word in, one result out; sustained rate one word per cycle while tx is ready.
// An accepted rx word passes through a 4-entry queue and then the result register to tx.
// The parser state and result register update once per popped word.
// Reset (arst_n low) clears the queue and parser; the block is ready at once.
// rx stalls only when the queue is full; tx stalls hold the result register.
module http_response_body_extractor (
	input logic        clk,
	input logic        arst_n,
	hrbe_in_if.sink    rx,
	hrbe_out_if.source tx
);

	hrbe_pkg::cls_t push_word;
	hrbe_pkg::cls_t pop_word;
	logic           push;
	logic           full;
	logic           pop;
	logic           rvalid;

	hrbe_front u_front (
		.rx   (rx),
		.full (full),
		.push (push),
		.word (push_word)
	);

	hrbe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_word),
		.full   (full),
		.pop    (pop),
		.rvalid (rvalid),
		.rdata  (pop_word)
	);

	hrbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (rvalid),
		.word       (pop_word),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		P_SKIP_VERSION,
		P_STATUS,
		P_REASON,
		P_LINE_START,
		P_HDR_NAME,
		P_PRE_VALUE,
		P_HDR_VALUE,
		P_BODY,
		P_DONE,
		P_ERROR
	} parse_phase_e;

	typedef enum {KEY_EXACT, KEY_CUT, KEY_ALTERED, KEY_EXTENDED} key_form_e;
	typedef enum {LEN_NEGATIVE, LEN_NO_DIGITS, LEN_ONE, LEN_SATURATED, LEN_COUNTED} len_form_e;

	localparam int VAL_STARTED = 0;
	localparam int VAL_NEG     = 1;
	localparam int VAL_STOP    = 2;

	localparam logic [8*hrbe_pkg::KEY_LEN-1:0] LEN_KEY = "content-length";
	localparam logic [hrbe_pkg::LEN_BITS-1:0]  LEN_MAX = '1;

	logic clk;
	logic arst_n;

	hrbe_in_if  rx_if();
	hrbe_out_if tx_if();

	http_response_body_extractor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	parse_phase_e                  hdr_phase     = P_SKIP_VERSION;
	logic [1:0]                    status_digits = '0;
	logic [hrbe_pkg::POS_BITS-1:0] key_pos       = '0;
	logic                          key_miss      = 1'b0;
	logic [hrbe_pkg::LEN_BITS-1:0] len_accum     = '0;
	logic [2:0]                    val_flags     = '0;
	logic [hrbe_pkg::LEN_BITS-1:0] body_left     = '0;

	hrbe_pkg::res_t pending_results[$];
	hrbe_pkg::res_t want_res;
	int   sent_words     = 0;
	int   result_count   = 0;
	int   mismatch_count = 0;
	int   send_gap_pct   = 0;
	int   recv_gap_pct   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_space(logic [7:0] b);
		return (b >= hrbe_pkg::CH_TAB && b <= hrbe_pkg::CH_CR) || b == hrbe_pkg::CH_SPACE;
	endfunction

	function automatic logic is_num(logic [7:0] b);
		return b >= hrbe_pkg::CH_ZERO && b <= hrbe_pkg::CH_NINE;
	endfunction

	function automatic void feed_name(logic [7:0] b);
		logic [7:0] c;
		c = (b >= hrbe_pkg::CH_UP_A && b <= hrbe_pkg::CH_UP_Z) ? b + hrbe_pkg::CASE_GAP : b;
		if (key_pos >= hrbe_pkg::KEY_LEN) begin
			key_miss = 1'b1;
		end else begin
			if (LEN_KEY[8*(hrbe_pkg::KEY_LEN-1-int'(key_pos)) +: 8] != c)
				key_miss = 1'b1;
			key_pos++;
		end
	endfunction

	function automatic void feed_value(logic [7:0] b);
		logic [hrbe_pkg::LEN_BITS-1:0] d;
		if (val_flags[VAL_STOP])
			return;
		if (!val_flags[VAL_STARTED]) begin
			val_flags[VAL_STARTED] = 1'b1;
			if (b == hrbe_pkg::CH_PLUS)
				return;
			if (b == hrbe_pkg::CH_MINUS) begin
				val_flags[VAL_NEG] = 1'b1;
				return;
			end
		end
		if (is_num(b)) begin
			d = hrbe_pkg::LEN_BITS'(b - hrbe_pkg::CH_ZERO);
			if (len_accum > (LEN_MAX - d) / 10)
				len_accum = LEN_MAX;
			else
				len_accum = len_accum * 10 + d;
		end else begin
			val_flags[VAL_STOP] = 1'b1;
		end
	endfunction

	function automatic hrbe_pkg::res_t parse_byte(logic [7:0] b);
		hrbe_pkg::res_t r;
		r = '0;
		case (hdr_phase)
			P_SKIP_VERSION: if (is_space(b)) begin
				status_digits = '0;
				hdr_phase = P_STATUS;
			end
			P_STATUS: if (status_digits < hrbe_pkg::STATUS_DIGITS) begin
				if (is_num(b))
					status_digits++;
				else
					hdr_phase = P_ERROR;
			end else begin
				hdr_phase = is_space(b) ? P_REASON : P_ERROR;
			end
			P_REASON: if (b == hrbe_pkg::CH_LF)
				hdr_phase = P_LINE_START;
			P_LINE_START: if (b == hrbe_pkg::CH_LF) begin
				hdr_phase = P_BODY;
			end else if (b != hrbe_pkg::CH_CR) begin
				key_pos = '0;
				key_miss = 1'b0;
				if (b == hrbe_pkg::CH_COLON) begin
					hdr_phase = P_PRE_VALUE;
				end else begin
					hdr_phase = P_HDR_NAME;
					feed_name(b);
				end
			end
			P_HDR_NAME: if (b == hrbe_pkg::CH_COLON)
				hdr_phase = P_PRE_VALUE;
			else
				feed_name(b);
			P_PRE_VALUE: if (!is_space(b)) begin
				len_accum = '0;
				val_flags = '0;
				hdr_phase = P_HDR_VALUE;
				feed_value(b);
			end
			P_HDR_VALUE: if (b == hrbe_pkg::CH_LF) begin
				if (!key_miss && key_pos == hrbe_pkg::KEY_LEN)
					body_left = val_flags[VAL_NEG] ? '0 : len_accum;
				hdr_phase = P_LINE_START;
			end else begin
				feed_value(b);
			end
			P_BODY: begin
				r.body_valid = 1'b1;
				r.body_byte = b;
				if (body_left <= 1) begin
					body_left = '0;
					r.body_last = 1'b1;
					hdr_phase = P_DONE;
				end else begin
					body_left--;
				end
			end
			default: ;
		endcase
		r.parse_error = (hdr_phase == P_ERROR);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("word %0d: %s got 0x%02h want 0x%02h", result_count, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && tx_if.valid && tx_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", tx_if.body_byte, 8'h00);
			end else begin
				want_res = pending_results.pop_front();
				if (tx_if.body_valid !== want_res.body_valid)
					report_mismatch("body_valid", 8'(tx_if.body_valid), 8'(want_res.body_valid));
				if (tx_if.body_byte !== want_res.body_byte)
					report_mismatch("body_byte", tx_if.body_byte, want_res.body_byte);
				if (tx_if.body_last !== want_res.body_last)
					report_mismatch("body_last", 8'(tx_if.body_last), 8'(want_res.body_last));
				if (tx_if.parse_error !== want_res.parse_error)
					report_mismatch("parse_error", 8'(tx_if.parse_error),
						8'(want_res.parse_error));
			end
			result_count++;
		end
		tx_if.ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	task automatic send_word(input logic [7:0] b);
		if (sent_words < 550) begin
			send_gap_pct = 35;
			recv_gap_pct = 48;
		end else if (sent_words < 1100) begin
			send_gap_pct = 48;
			recv_gap_pct = 35;
		end else begin
			send_gap_pct = 0;
			recv_gap_pct = 0;
		end
		while ($urandom_range(99) < send_gap_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.byte_in <= b;
		do @(posedge clk); while (!rx_if.ready);
		pending_results.push_back(parse_byte(b));
		sent_words++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(s[i]);
	endtask

	function automatic logic [7:0] rand_space();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? hrbe_pkg::CH_SPACE : hrbe_pkg::CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] rand_name_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (b == hrbe_pkg::CH_COLON || b == hrbe_pkg::CH_LF || b == hrbe_pkg::CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] rand_line_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == hrbe_pkg::CH_LF);
		return b;
	endfunction

	task automatic send_junk_name(input int n);
		repeat (n) send_word(rand_name_byte());
	endtask

	task automatic send_key(input key_form_e form);
		int cut;
		int hit;
		int k;
		logic [7:0] c;
		cut = (form == KEY_CUT) ? $urandom_range(1, hrbe_pkg::KEY_LEN - 1) : hrbe_pkg::KEY_LEN;
		hit = (form == KEY_ALTERED) ? $urandom_range(hrbe_pkg::KEY_LEN - 1) : hrbe_pkg::KEY_LEN;
		for (k = 0; k < cut; k++) begin
			c = LEN_KEY[8*(hrbe_pkg::KEY_LEN-1-k) +: 8];
			if (k == hit)
				c = rand_name_byte();
			else if (c >= "a" && c <= "z" && $urandom_range(1))
				c = c - hrbe_pkg::CASE_GAP;
			send_word(c);
		end
		if (form == KEY_EXTENDED)
			send_junk_name($urandom_range(1, 3));
		send_word(hrbe_pkg::CH_COLON);
	endtask

	task automatic send_value();
		int sign;
		int ndig;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) send_word(rand_space());
		sign = $urandom_range(5);
		if (sign == 0)
			send_word(hrbe_pkg::CH_PLUS);
		else if (sign == 1)
			send_word(hrbe_pkg::CH_MINUS);
		ndig = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
		repeat (ndig) send_word(hrbe_pkg::CH_ZERO + 8'($urandom_range(9)));
		repeat ($urandom_range(0, 2)) send_word(rand_line_byte());
		if ($urandom_range(1))
			send_word(hrbe_pkg::CH_CR);
		send_word(hrbe_pkg::CH_LF);
	endtask

	task automatic random_header();
		int kind;
		kind = $urandom_range(9);
		if ($urandom_range(7) == 0)
			send_word(hrbe_pkg::CH_CR);
		case (kind)
			0, 1, 9: send_key(KEY_EXACT);
			2, 3: send_key(key_form_e'($urandom_range(1, 3)));
			7: send_word(hrbe_pkg::CH_COLON);
			8: begin
				send_junk_name($urandom_range(1, 4));
				send_word(hrbe_pkg::CH_CR);
				send_word(hrbe_pkg::CH_LF);
				send_junk_name($urandom_range(1, 6));
				send_word(hrbe_pkg::CH_COLON);
			end
			default: begin
				send_junk_name($urandom_range(1, 12));
				send_word(hrbe_pkg::CH_COLON);
			end
		endcase
		send_value();
	endtask

	task automatic test_status_line();
		int fault;
		logic [7:0] b;
		fault = $urandom_range(15);
		send_word(8'h00);
		send_word(8'hff);
		send_word("H");
		send_word(hrbe_pkg::CH_TAB);
		send_word(hrbe_pkg::CH_ZERO);
		send_word(hrbe_pkg::CH_NINE);
		if (fault == 1) begin
			do b = 8'($urandom_range(255)); while (is_num(b));
			send_word(b);
		end else begin
			send_word("5");
		end
		if (fault == 2) begin
			do b = 8'($urandom_range(255)); while (is_space(b));
			send_word(b);
		end else begin
			send_word(hrbe_pkg::CH_CR);
		end
		send_word(8'hff);
		send_word(hrbe_pkg::CH_SPACE);
		send_word(hrbe_pkg::CH_LF);
	endtask

	task automatic test_header_forms();
		send_word(hrbe_pkg::CH_CR);
		send_text("CONTENT-length:");
		send_word(hrbe_pkg::CH_SPACE);
		send_word(hrbe_pkg::CH_LF);
		send_text("+9x");
		send_word(hrbe_pkg::CH_LF);
	endtask

	task automatic test_random_headers();
		while (sent_words < 950)
			random_header();
	endtask

	task automatic test_body_framing();
		len_form_e form;
		int pick;
		int body_words;
		pick = $urandom_range(9);
		form = (pick < 4) ? len_form_e'(pick) : LEN_COUNTED;
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		// close any header left open by an empty value
		send_text("x:0");
		send_word(hrbe_pkg::CH_LF);
		send_text("Content-Length:");
		case (form)
			LEN_NEGATIVE: begin
				send_text("-42");
				body_words = 1;
			end
			LEN_NO_DIGITS: begin
				send_text("n/a");
				body_words = 1;
			end
			LEN_ONE: begin
				send_text("1");
				body_words = 1;
			end
			LEN_SATURATED: begin
				send_text("99999999999");
				body_words = 650;
			end
			default: begin
				body_words = $urandom_range(100, 700);
				send_text($sformatf("%0d", body_words));
			end
		endcase
		send_word(hrbe_pkg::CH_CR);
		send_word(hrbe_pkg::CH_LF);
		send_word(hrbe_pkg::CH_CR);
		send_word(hrbe_pkg::CH_LF);
		repeat (body_words) send_word(8'($urandom_range(255)));
	endtask

	task automatic test_trailing();
		repeat (30) send_word(8'($urandom_range(255)));
		while (sent_words < 1650)
			send_word(8'($urandom_range(255)));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.byte_in = '0;
		tx_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_status_line();
		test_header_forms();
		test_random_headers();
		test_body_framing();
		test_trailing();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
